FILE: sv/lerb_pkg.sv
// Shared constants, types and pointer helpers for the line-editing receive buffer.
package lerb_pkg;

  localparam int BUF_DEPTH = 128;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_SP  = 8'd32;

  localparam logic [7:0] LINES_MAX = 8'd255;

  localparam logic ACT_RX  = 1'b0;
  localparam logic ACT_POP = 1'b1;

  localparam logic [2:0] KIND_ECHO  = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_EOL   = 3'd2;
  localparam logic [2:0] KIND_EMPTY = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;

  // One item's results: a single result, or the three-beat erase echo.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       erase;
    logic       wake;
    logic [7:0] lines;
    logic       full;
  } grp_t;

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } mem_req_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(BUF_DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

FILE: sv/lerb_store.sv
// Character ring storage with a registered read port and write-to-read bypass.
module lerb_store
  import lerb_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // A read of the entry written at the same edge must see the new byte.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
        rd_data_r <= req.wr_data;
      end else begin
        rd_data_r <= mem[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/lerb_core.sv
// Input register, buffer state and the per-item editing decision.
module lerb_core
  import lerb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_action,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  output mem_req_t   mem_req,
  input  logic [7:0] rd_data,
  input  logic       grp_ready,
  output logic       grp_valid,
  output grp_t       grp
);

  logic             s1_valid_r;
  logic             s1_action_r;
  logic [7:0]       s1_byte_r;

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [7:0]       lines_r, lines_nxt;
  logic             full_r, full_nxt;
  // Bytes at the tail of the ring that DEL may still take back.
  logic [CNT_W-1:0] erasable_r, erasable_nxt;

  logic [CNT_W-1:0] stored;
  logic             commit;
  logic             accept;
  logic [7:0]       wdata;
  logic             wr_en;
  grp_t             g;

  assign commit   = s1_valid_r && grp_ready;
  assign in_ready = !s1_valid_r || grp_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (full_r) begin
      stored = CNT_W'(BUF_DEPTH);
    end else if (wp_r >= rp_r) begin
      stored = CNT_W'(wp_r) - CNT_W'(rp_r);
    end else begin
      stored = CNT_W'(wp_r) + CNT_W'(BUF_DEPTH) - CNT_W'(rp_r);
    end
  end

  always_comb begin
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    lines_nxt    = lines_r;
    full_nxt     = full_r;
    erasable_nxt = erasable_r;
    wr_en        = 1'b0;
    wdata        = (s1_byte_r == CH_CR) ? CH_LF : s1_byte_r;
    g.kind       = KIND_NONE;
    g.data       = '0;
    g.erase      = 1'b0;
    g.wake       = 1'b0;
    if (commit) begin
      if (s1_action_r == ACT_POP) begin
        if (lines_r == '0 && !full_r) begin
          g.kind = KIND_EMPTY;
        end else begin
          rp_nxt   = ptr_inc(rp_r);
          full_nxt = 1'b0;
          if (erasable_r != '0 && erasable_r == stored) begin
            erasable_nxt = erasable_r - 1'b1;
          end
          if (rd_data == CH_LF) begin
            if (lines_r != '0) begin
              lines_nxt = lines_r - 1'b1;
            end
            g.kind = KIND_EOL;
            g.data = CH_LF;
          end else begin
            g.kind = KIND_READ;
            g.data = rd_data;
          end
        end
      end else if (s1_byte_r == CH_DEL) begin
        if (wp_r != rp_r && erasable_r != '0) begin
          wp_nxt       = ptr_dec(wp_r);
          full_nxt     = 1'b0;
          erasable_nxt = erasable_r - 1'b1;
          g.kind       = KIND_ECHO;
          g.erase      = 1'b1;
        end
      end else if (full_r) begin
        g.wake = 1'b1;
      end else begin
        wr_en  = 1'b1;
        wp_nxt = ptr_inc(wp_r);
        if (ptr_inc(wp_r) == rp_r) begin
          full_nxt = 1'b1;
        end
        if (s1_byte_r == CH_CR) begin
          g.wake = 1'b1;
          if (lines_r != LINES_MAX) begin
            lines_nxt = lines_r + 1'b1;
          end
        end
        erasable_nxt = (wdata == CH_LF) ? '0 : erasable_r + 1'b1;
        g.kind = KIND_ECHO;
        g.data = wdata;
      end
    end
    g.lines = lines_nxt;
    g.full  = full_nxt;
  end

  assign grp       = g;
  assign grp_valid = commit;

  assign mem_req.wr_en   = wr_en;
  assign mem_req.wr_addr = wp_r;
  assign mem_req.wr_data = wdata;
  assign mem_req.rd_en   = accept;
  assign mem_req.rd_addr = rp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wp_r       <= '0;
      rp_r       <= '0;
      lines_r    <= '0;
      full_r     <= 1'b0;
      erasable_r <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      lines_r    <= lines_nxt;
      full_r     <= full_nxt;
      erasable_r <= erasable_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_byte;
    end
  end

  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (wp_r == rp_r))
    else $error("full flag set while pointers differ");

  a_erasable_bound: assert property (@(posedge clk) disable iff (!rst_n)
    erasable_r <= stored)
    else $error("erasable count exceeds stored bytes");

  a_lines_need_data: assert property (@(posedge clk) disable iff (!rst_n)
    (lines_r != '0) |-> (stored != '0))
    else $error("pending lines counted in an empty ring");

  a_hold_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !grp_ready) |=> (s1_valid_r && $stable(wp_r) && $stable(rp_r)))
    else $error("state moved while the held item waited");

endmodule

FILE: sv/lerb_out.sv
// Result register that plays out one result per beat, three for an erase echo.
module lerb_out
  import lerb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       grp_valid,
  input  grp_t       grp,
  output logic       grp_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_data,
  output logic       out_last,
  output logic       out_wake,
  output logic [7:0] out_lines,
  output logic       out_full
);

  logic       valid_r;
  grp_t       grp_r;
  logic [1:0] beat_r;
  logic       take;

  assign out_valid = valid_r;
  assign out_last  = !grp_r.erase || (beat_r == 2'd2);
  assign out_kind  = grp_r.kind;
  assign out_data  = grp_r.erase ? ((beat_r == 2'd1) ? CH_SP : CH_BS) : grp_r.data;
  assign out_wake  = grp_r.wake;
  assign out_lines = grp_r.lines;
  assign out_full  = grp_r.full;

  assign take      = valid_r && out_ready;
  assign grp_ready = !valid_r || (take && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else if (grp_ready) begin
      valid_r <= grp_valid;
      beat_r  <= '0;
    end else if (take) begin
      beat_r <= beat_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_ready && grp_valid) begin
      grp_r <= grp;
    end
  end

  a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (beat_r == 2'd0 || (grp_r.erase && (beat_r == 2'd1 || beat_r == 2'd2))))
    else $error("beat counter outside the result group");

endmodule

FILE: sv/line_edit_receive_buffer.sv
// Top level of the line-editing receive buffer.
//
//  channel  direction  tdata                                  tuser      tlast
//  in_      slave      rx_byte                                action     -
//  out_     master     data, wake_reader, pending_lines, full kind       last
//
// An item is registered, then decided at the next edge at which the result register is
// free, using the byte read from the ring at the read pointer; single-result items
// stream at one per cycle while out_tready is high. An erasing DEL holds the result
// register for three beats. Reset is synchronous and clears pointers, flags and the
// line count; the ring needs no clearing. While the result side stalls or an erase
// plays out, the next item waits in the input register with in_tready low.
module line_edit_receive_buffer
  import lerb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data, [8] wake_reader, [16:9] pending_lines,
                                  // [17] full_flag, [23:18] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast
);

  mem_req_t   mem_req;
  logic [7:0] rd_data;
  logic       grp_valid;
  logic       grp_ready;
  grp_t       grp;
  logic [7:0] o_data;
  logic       o_wake;
  logic [7:0] o_lines;
  logic       o_full;

  lerb_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser[0]),
    .in_byte   (in_tdata),
    .in_ready  (in_tready),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .grp_ready (grp_ready),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  lerb_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  lerb_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_ready (grp_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_data  (o_data),
    .out_last  (out_tlast),
    .out_wake  (o_wake),
    .out_lines (o_lines),
    .out_full  (o_full)
  );

  assign out_tdata = {6'd0, o_full, o_lines, o_wake, o_data};

endmodule
